FILE: hw/rtl/ovn_pkg.sv
package ovn_pkg;

    localparam int OCTAVES         = 4;
    localparam int MAX_DIM         = 1024;
    localparam int COS_TABLE_DEPTH = 256;

    localparam int PIX_W    = 10;
    localparam int COS_BITS = $clog2(COS_TABLE_DEPTH);
    localparam int W_W      = 17;
    localparam int TERM_W   = 32;
    localparam int SUM_W    = TERM_W + $clog2(OCTAVES) + 1;

    localparam int SCALE_LAT = OCTAVES;
    localparam int LANE_LAT  = 9;
    localparam int SUM_LAT   = 2;
    localparam int LATENCY   = SCALE_LAT + LANE_LAT + SUM_LAT;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    localparam logic REG_FREQ_RATIO    = 1'b0;
    localparam logic REG_INV_AMP_RATIO = 1'b1;

    typedef logic [31:0] t_q16;

    // Restoring long division used while the weight table is built.
    function automatic longint unsigned f_udiv(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Builds the cosine weight table at elaboration time. Entry k holds
    // round((1 - cos(pi * k / depth)) / 2) in Q0.16, using a truncated
    // Taylor series and mirroring the upper half.
    function automatic logic [COS_TABLE_DEPTH*W_W-1:0] f_cos_rom();
        logic [COS_TABLE_DEPTH*W_W-1:0] rom;
        longint unsigned ang;
        longint unsigned x2u;
        longint          x2;
        longint          r;
        longint          dv;
        longint          wh;
        longint          val;
        int              kk;
        rom = '0;
        for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
            kk  = (2 * k <= COS_TABLE_DEPTH) ? k : COS_TABLE_DEPTH - k;
            ang = f_udiv(64'd3373259426 * longint'(kk), 64'(COS_TABLE_DEPTH));
            x2u = (ang * ang) >> 30;
            x2  = longint'(x2u);
            r   = 64'sd1 << 30;
            // Every partial product stays non-negative until the last step.
            for (int j = 7; j >= 1; j--) begin
                dv = longint'((2 * j - 1) * (2 * j));
                r  = (64'sd1 << 30)
                   - longint'(f_udiv($unsigned(x2 * r), $unsigned(dv)) >> 30);
            end
            if (r < 0) begin
                r = 0;
            end
            if (r > (64'sd1 << 30)) begin
                r = 64'sd1 << 30;
            end
            wh  = ((64'sd1 << 30) - r + 64'sd16384) >>> 15;
            val = (2 * k <= COS_TABLE_DEPTH) ? wh : 64'sd65536 - wh;
            rom[k*W_W +: W_W] = W_W'(val);
        end
        return rom;
    endfunction

    localparam logic [COS_TABLE_DEPTH*W_W-1:0] COS_ROM = f_cos_rom();

endpackage

FILE: hw/rtl/octave_value_noise_pixel.sv
// Fractal value-noise texel generator, one pixel per item.
// Drive i_pix_x / i_pix_y with start high to issue an item; busy is always
// low, so an item is taken at every clock edge where start is high, one per
// cycle without gaps. Each item produces exactly one result: o_valid is high
// for one cycle with o_gray_level and o_pixel_word (the grey byte copied to
// all four bytes). The receiver cannot hold results off.
// One stage per octave derives the octave scales, nine stages per octave
// lane do the coordinate multiply, hash, and interpolation, and two stages
// sum, clamp and scale. Throughput is one item per cycle.
// The two ratio registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data and must only change while no item is in flight.
// Reset (i_rst_n low at a clock edge) restores freq_ratio to 2.0 and
// inv_amp_ratio to 0.5 and drops every item in flight.
module octave_value_noise_pixel import ovn_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [9:0]   i_pix_x,
    input  logic [9:0]   i_pix_y,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    output logic         o_valid,
    output logic [31:0]  o_pixel_word,
    output logic [7:0]   o_gray_level
);

    localparam logic [PIX_W-1:0] DIM_MASK = PIX_W'(MAX_DIM - 1);

    logic [15:0]        r_freq_ratio;
    logic [15:0]        r_inv_amp_ratio;
    logic [LATENCY-1:0] r_vld;

    logic [PIX_W-1:0]          px;
    logic [PIX_W-1:0]          py;
    logic [PIX_W-1:0]          sc_px;
    logic [PIX_W-1:0]          sc_py;
    t_q16                      sc_s [OCTAVES];
    t_q16                      sc_g [OCTAVES];
    logic signed [TERM_W-1:0]  term [OCTAVES];
    logic [7:0]                gray;
    logic                      accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Pixel coordinates wrap at the texture size.
    assign px = i_pix_x & DIM_MASK;
    assign py = i_pix_y & DIM_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_ratio    <= 16'd8192;
            r_inv_amp_ratio <= 16'd2048;
            r_vld           <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FREQ_RATIO:    r_freq_ratio    <= i_cfg_data;
                    REG_INV_AMP_RATIO: r_inv_amp_ratio <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_vld <= {r_vld[LATENCY-2:0], accept};
        end
    end

    ovn_scale u_scale (
        .i_clk  (i_clk),
        .i_px   (px),
        .i_py   (py),
        .i_freq (r_freq_ratio),
        .i_amp  (r_inv_amp_ratio),
        .o_px   (sc_px),
        .o_py   (sc_py),
        .o_s    (sc_s),
        .o_g    (sc_g)
    );

    // One interpolation lane per octave, all running side by side.
    for (genvar n = 0; n < OCTAVES; n++) begin : g_lane
        ovn_lane u_lane (
            .i_clk  (i_clk),
            .i_px   (sc_px),
            .i_py   (sc_py),
            .i_s    (sc_s[n]),
            .i_g    (sc_g[n]),
            .o_term (term[n])
        );
    end

    ovn_sum u_sum (
        .i_clk  (i_clk),
        .i_term (term),
        .o_gray (gray)
    );

    assign o_valid      = r_vld[LATENCY-1];
    assign o_gray_level = gray;
    assign o_pixel_word = {4{gray}};

    // A result only appears where a matching item was taken earlier.
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LATENCY))
        else $error("result without a matching item");

    // Every accepted item leaves as a result, unless a reset drops it.
    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && $past(i_rst_n, 1) && r_vld[0] == r_vld[0]) |-> ##LATENCY
        (o_valid || !i_rst_n || $past(!i_rst_n, 1)))
        else $error("item lost in pipeline");

    a_word_matches_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_word[31:24] == o_gray_level
                     && o_pixel_word[7:0] == o_gray_level))
        else $error("texel bytes disagree with grey level");

endmodule

FILE: hw/rtl/ovn_scale.sv
module ovn_scale import ovn_pkg::*; (
    input  logic             i_clk,
    input  logic [PIX_W-1:0] i_px,
    input  logic [PIX_W-1:0] i_py,
    input  logic [15:0]      i_freq,
    input  logic [15:0]      i_amp,
    output logic [PIX_W-1:0] o_px,
    output logic [PIX_W-1:0] o_py,
    output t_q16             o_s [OCTAVES],
    output t_q16             o_g [OCTAVES]
);

    logic [PIX_W-1:0] r_px   [OCTAVES];
    logic [PIX_W-1:0] r_py   [OCTAVES];
    logic [15:0]      r_freq [OCTAVES];
    logic [15:0]      r_amp  [OCTAVES];
    t_q16             r_s    [OCTAVES][OCTAVES];
    t_q16             r_g    [OCTAVES][OCTAVES];

    // Q16.16 times Q4.12, saturating at all ones.
    function automatic t_q16 f_mul_sat(input t_q16 a, input logic [15:0] b);
        logic [47:0] p;
        p = 48'(a) * 48'(b);
        return (|p[47:44]) ? '1 : p[43:12];
    endfunction

    // Stage k derives the scale and amplitude of octave k.
    always_ff @(posedge i_clk) begin
        r_px[0]   <= i_px;
        r_py[0]   <= i_py;
        r_freq[0] <= i_freq;
        r_amp[0]  <= i_amp;
        for (int i = 0; i < OCTAVES; i++) begin
            r_s[0][i] <= ONE_Q16;
            r_g[0][i] <= ONE_Q16;
        end
        for (int k = 1; k < OCTAVES; k++) begin
            r_px[k]   <= r_px[k-1];
            r_py[k]   <= r_py[k-1];
            r_freq[k] <= r_freq[k-1];
            r_amp[k]  <= r_amp[k-1];
            for (int i = 0; i < OCTAVES; i++) begin
                if (i == k) begin
                    r_s[k][i] <= f_mul_sat(r_s[k-1][k-1], r_freq[k-1]);
                    r_g[k][i] <= f_mul_sat(r_g[k-1][k-1], r_amp[k-1]);
                end else begin
                    r_s[k][i] <= r_s[k-1][i];
                    r_g[k][i] <= r_g[k-1][i];
                end
            end
        end
    end

    assign o_px = r_px[OCTAVES-1];
    assign o_py = r_py[OCTAVES-1];
    assign o_s  = r_s[OCTAVES-1];
    assign o_g  = r_g[OCTAVES-1];

endmodule

FILE: hw/rtl/ovn_lane.sv
module ovn_lane import ovn_pkg::*; (
    input  logic                     i_clk,
    input  logic [PIX_W-1:0]         i_px,
    input  logic [PIX_W-1:0]         i_py,
    input  t_q16                     i_s,
    input  t_q16                     i_g,
    output logic signed [TERM_W-1:0] o_term
);

    localparam int MX_W = PIX_W + 32;

    t_q16               r_cx;
    t_q16               r_cy;
    t_q16               r_g [8];
    logic [31:0]        r_n2 [4];
    logic [31:0]        r_n3 [4];
    logic [31:0]        r_n4 [4];
    logic [31:0]        r_sq [4];
    logic [31:0]        r_t  [4];
    logic signed [17:0] r_lat [4];
    logic [W_W-1:0]     r_wx [4];
    logic [W_W-1:0]     r_wy [5];
    logic signed [17:0] r_top;
    logic signed [17:0] r_bot;
    logic signed [17:0] r_v;
    logic signed [31:0] r_v6;
    logic signed [TERM_W-1:0] r_term;

    logic [MX_W-1:0]     mx;
    logic [MX_W-1:0]     my;
    logic [31:0]         n00;
    logic [31:0]         n_raw [4];
    logic [COS_BITS-1:0] kx;
    logic [COS_BITS-1:0] ky;
    logic [31:0]         m [4];
    logic signed [64:0]  prod;

    function automatic logic signed [17:0] f_blend(input logic signed [17:0] a,
                                                   input logic signed [17:0] b,
                                                   input logic [W_W-1:0]     w);
        logic signed [17:0] wa;
        logic signed [17:0] wb;
        logic signed [36:0] acc;
        wb  = signed'({1'b0, w});
        wa  = 18'sd65536 - wb;
        acc = 37'(a * wa) + 37'(b * wb);
        return acc[33:16];
    endfunction

    assign mx = MX_W'(i_px) * MX_W'(i_s);
    assign my = MX_W'(i_py) * MX_W'(i_s);

    // Lattice corners around the integer part; the fraction picks weights.
    assign n00      = 32'(r_cx[31:16]) + 32'(r_cy[31:16]) * 32'd57;
    assign n_raw[0] = n00;
    assign n_raw[1] = n00 + 32'd1;
    assign n_raw[2] = n00 + 32'd57;
    assign n_raw[3] = n00 + 32'd58;
    assign kx = r_cx[15 -: COS_BITS];
    assign ky = r_cy[15 -: COS_BITS];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            m[i] = (r_n4[i] * r_t[i] + 32'd1376312589) & 32'h7fff_ffff;
        end
    end

    assign prod = 65'(r_v6) * signed'({1'b0, r_g[7]});

    always_ff @(posedge i_clk) begin
        r_cx   <= (|mx[MX_W-1:32]) ? '1 : mx[31:0];
        r_cy   <= (|my[MX_W-1:32]) ? '1 : my[31:0];
        r_g[0] <= i_g;
        for (int k = 1; k < 8; k++) begin
            r_g[k] <= r_g[k-1];
        end

        r_wx[0] <= COS_ROM[kx*W_W +: W_W];
        r_wy[0] <= COS_ROM[ky*W_W +: W_W];
        for (int k = 1; k < 4; k++) begin
            r_wx[k] <= r_wx[k-1];
        end
        for (int k = 1; k < 5; k++) begin
            r_wy[k] <= r_wy[k-1];
        end

        for (int i = 0; i < 4; i++) begin
            r_n2[i]  <= (n_raw[i] << 13) ^ n_raw[i];
            r_sq[i]  <= r_n2[i] * r_n2[i];
            r_n3[i]  <= r_n2[i];
            r_t[i]   <= r_sq[i] * 32'd15731 + 32'd789221;
            r_n4[i]  <= r_n3[i];
            r_lat[i] <= 18'sd65536 - signed'({1'b0, m[i][30:14]});
        end

        r_top  <= f_blend(r_lat[0], r_lat[1], r_wx[3]);
        r_bot  <= f_blend(r_lat[2], r_lat[3], r_wx[3]);
        r_v    <= f_blend(r_top, r_bot, r_wy[4]);
        r_v6   <= 32'(r_v * 18'sd6554);
        r_term <= prod[63:32];
    end

    assign o_term = r_term;

endmodule

FILE: hw/rtl/ovn_sum.sv
module ovn_sum import ovn_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [TERM_W-1:0] i_term [OCTAVES],
    output logic [7:0]               o_gray
);

    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] sum;
    logic [16:0]             clamped;
    logic [24:0]             scaled;
    logic [7:0]              r_gray;

    always_comb begin
        sum = '0;
        for (int i = 0; i < OCTAVES; i++) begin
            sum = sum + SUM_W'(i_term[i]);
        end
    end

    always_comb begin
        if (r_sum < 0) begin
            clamped = '0;
        end else if (r_sum > SUM_W'(65536)) begin
            clamped = 17'd65536;
        end else begin
            clamped = r_sum[16:0];
        end
    end

    assign scaled = (25'(clamped) << 8) - 25'(clamped);

    always_ff @(posedge i_clk) begin
        r_sum  <= sum;
        r_gray <= scaled[23:16];
    end

    assign o_gray = r_gray;

endmodule
